@@ hdl/sce_pkg.sv @@
// Shared constants, codes and tables for the sine/cosine encoder angle decoder.
// No dependencies; used by sce_cordic and sincos_encoder_angle_top.
package sce_pkg;

  localparam int SampleBits  = 14;
  localparam int CordicSteps = 20;
  localparam int StepBits    = 5;
  localparam int ZBits       = 26;
  localparam int AngleBits   = 17;

  localparam logic signed [AngleBits-1:0] AngleLimit = 17'sd46080;

  // round(2^24 / 20000)
  localparam logic [9:0] RateK = 10'd839;

  localparam logic [1:0] STATUS_VALID = 2'd0;
  localparam logic [1:0] STATUS_ABOVE = 2'd1;
  localparam logic [1:0] STATUS_BELOW = 2'd2;

  localparam logic [2:0] REG_SIN_GAIN   = 3'd0;
  localparam logic [2:0] REG_SIN_OFFSET = 3'd1;
  localparam logic [2:0] REG_COS_GAIN   = 3'd2;
  localparam logic [2:0] REG_COS_OFFSET = 3'd3;
  localparam logic [2:0] REG_FILT_GAIN  = 3'd4;
  localparam logic [2:0] REG_MIN_MAG    = 3'd5;
  localparam logic [2:0] REG_MAX_MAG    = 3'd6;

  // atan(2^-i) in degrees Q8.16
  function automatic logic signed [ZBits-1:0] atan_q16(input logic [StepBits-1:0] idx);
    logic signed [ZBits-1:0] v;
    case (idx)
      5'd0:    v = 26'sd2949120;
      5'd1:    v = 26'sd1740967;
      5'd2:    v = 26'sd919879;
      5'd3:    v = 26'sd466945;
      5'd4:    v = 26'sd234379;
      5'd5:    v = 26'sd117304;
      5'd6:    v = 26'sd58666;
      5'd7:    v = 26'sd29335;
      5'd8:    v = 26'sd14668;
      5'd9:    v = 26'sd7334;
      5'd10:   v = 26'sd3667;
      5'd11:   v = 26'sd1833;
      5'd12:   v = 26'sd917;
      5'd13:   v = 26'sd458;
      5'd14:   v = 26'sd229;
      5'd15:   v = 26'sd115;
      5'd16:   v = 26'sd57;
      5'd17:   v = 26'sd29;
      5'd18:   v = 26'sd14;
      5'd19:   v = 26'sd7;
      default: v = 26'sd0;
    endcase
    return v;
  endfunction

endpackage

@@ hdl/sce_cordic.sv @@
// Iterative vectoring CORDIC: one micro-rotation per cycle, angle in degrees.
// Depends on sce_pkg (step count, atan table, angle limit).
module sce_cordic (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start_i,
  input  logic signed [15:0]                 sin_i,
  input  logic signed [15:0]                 cos_i,
  output logic                               done_o,
  output logic signed [sce_pkg::AngleBits-1:0] angle_o
);

  logic signed [31:0]                x_q, x_d, y_q, y_d;
  logic signed [sce_pkg::ZBits-1:0]  z_q, z_d;
  logic [sce_pkg::StepBits-1:0]      i_q, i_d;
  logic                              run_q, run_d, done_q, done_d;
  logic signed [31:0]                xs, ys, x0, y0;
  logic signed [sce_pkg::ZBits:0]    zr;
  logic signed [sce_pkg::ZBits-8:0]  zs;

  assign x0 = 32'(cos_i) <<< 12;
  assign y0 = 32'(sin_i) <<< 12;
  assign xs = x_q >>> i_q;
  assign ys = y_q >>> i_q;

  always_comb begin
    x_d    = x_q;
    y_d    = y_q;
    z_d    = z_q;
    i_d    = i_q;
    run_d  = run_q;
    done_d = 1'b0;
    if (start_i) begin
      i_d = '0;
      if (sin_i == 16'sd0 && cos_i == 16'sd0) begin
        z_d    = '0;
        done_d = 1'b1;
      end else if (x0 < 0) begin
        run_d = 1'b1;
        if (y0 >= 0) begin
          x_d = y0;
          y_d = -x0;
          z_d = 26'sd5898240;
        end else begin
          x_d = -y0;
          y_d = x0;
          z_d = -26'sd5898240;
        end
      end else begin
        run_d = 1'b1;
        x_d   = x0;
        y_d   = y0;
        z_d   = '0;
      end
    end else if (run_q) begin
      if (y_q > 0) begin
        x_d = x_q + ys;
        y_d = y_q - xs;
        z_d = z_q + sce_pkg::atan_q16(i_q);
      end else begin
        x_d = x_q - ys;
        y_d = y_q + xs;
        z_d = z_q - sce_pkg::atan_q16(i_q);
      end
      i_d = i_q + 5'd1;
      if (i_q == 5'(sce_pkg::CordicSteps - 1)) begin
        run_d  = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      i_q    <= '0;
    end else begin
      run_q  <= run_d;
      done_q <= done_d;
      i_q    <= i_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q <= x_d;
    y_q <= y_d;
    z_q <= z_d;
  end

  // round Q8.16 to Q8.8, then clamp
  assign zr = (sce_pkg::ZBits+1)'(z_q) + 27'sd128;
  assign zs = zr[sce_pkg::ZBits:8];

  always_comb begin
    if (zs > 19'(sce_pkg::AngleLimit)) begin
      angle_o = sce_pkg::AngleLimit;
    end else if (zs < -19'(sce_pkg::AngleLimit)) begin
      angle_o = -sce_pkg::AngleLimit;
    end else begin
      angle_o = zs[sce_pkg::AngleBits-1:0];
    end
  end

  assign done_o = done_q;

endmodule

@@ hdl/sincos_encoder_angle_top.sv @@
// Sine/cosine encoder angle decoder: scaling, magnitude check, error rates,
// angle low-pass. Depends on sce_pkg and sce_cordic.
// A valid sample runs through scaling, the magnitude check, the rate updates,
// the CORDIC and the filter; a rejected one skips the CORDIC and the filter.
// One item at a time, set by the shared multiplier and the CORDIC: a new sample
// is taken only once the last result has left on m_axis.
// Reset: async active low; counters, rates and held angle clear, registers
// take their default values. No clearing pass.
module sincos_encoder_angle_top (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_we_i,
  input  logic [2:0]   cfg_idx_i,
  input  logic [31:0]  cfg_data_i,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [31:0]  s_axis_tdata,  // sine_volts[13:0], cosine_volts[27:14]
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // angle_deg[16:0], above_max_count[48:17], below_min_count[80:49],
  // above_max_rate[104:81], below_min_rate[128:105]
  output logic [135:0] m_axis_tdata,
  output logic [1:0]   m_axis_tuser   // sample_status
);

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_MUL_S    = 4'd1;
  localparam logic [3:0] S_MUL_C    = 4'd2;
  localparam logic [3:0] S_SQ_S     = 4'd3;
  localparam logic [3:0] S_SQ_C     = 4'd4;
  localparam logic [3:0] S_CHK      = 4'd5;
  localparam logic [3:0] S_RATE_L   = 4'd6;
  localparam logic [3:0] S_RATE_S   = 4'd7;
  localparam logic [3:0] S_CORD     = 4'd8;
  localparam logic [3:0] S_FILT_MUL = 4'd9;
  localparam logic [3:0] S_FILT_ADD = 4'd10;
  localparam logic [3:0] S_OUT      = 4'd11;

  localparam int SB = sce_pkg::SampleBits;
  localparam int AB = sce_pkg::AngleBits;

  logic [3:0] state_q, state_d;

  logic signed [15:0] sin_gain_q, sin_off_q, cos_gain_q, cos_off_q;
  logic [16:0]        filt_gain_q;
  logic [31:0]        min_mag_q, max_mag_q;

  logic [SB-1:0]      sin_raw_q, cos_raw_q;
  logic signed [15:0] s_q, c_q;
  logic [31:0]        mag_q;
  logic [1:0]         status_q;
  logic [31:0]        large_cnt_q, small_cnt_q;
  logic [23:0]        large_rate_q, small_rate_q;
  logic signed [AB-1:0] last_q, ang_q;
  logic signed [35:0] prod_q;

  logic signed [25:0] mul_a;
  logic signed [17:0] mul_b;
  logic signed [43:0] mul_p;

  logic               cord_start, cord_done;
  logic signed [AB-1:0] cord_angle;

  logic signed [20:0] ch_val;
  logic signed [15:0] ch_sat;
  logic signed [15:0] ch_off;
  logic [23:0]        rate_in;
  logic               rate_up;
  logic [23:0]        rate_new;
  logic [35:0]        rate_rnd;
  logic [11:0]        rate_d;
  logic [24:0]        rate_sum;
  logic signed [17:0] filt_k;
  logic signed [19:0] filt_q;
  logic signed [20:0] filt_sum;
  logic signed [AB-1:0] filt_new;

  assign s_axis_tready = (state_q == S_IDLE);
  assign m_axis_tvalid = (state_q == S_OUT);
  assign m_axis_tuser  = status_q;
  assign m_axis_tdata  = {7'd0, small_rate_q, large_rate_q, small_cnt_q, large_cnt_q,
                          last_q};

  // unity is 2^16, one bit past the register's signed range
  assign filt_k = (filt_gain_q > 17'h10000) ? 18'sh10000 : signed'({1'b0, filt_gain_q});

  // rate channel being updated in this cycle
  always_comb begin
    if (state_q == S_RATE_L) begin
      rate_in = large_rate_q;
    end else begin
      rate_in = small_rate_q;
    end
    rate_up = (status_q != sce_pkg::STATUS_VALID);
  end

  // shared multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_q)
      S_MUL_S: begin
        mul_a = signed'(26'(sin_raw_q));
        mul_b = 18'(sin_gain_q);
      end
      S_MUL_C: begin
        mul_a = signed'(26'(cos_raw_q));
        mul_b = 18'(cos_gain_q);
      end
      S_SQ_S: begin
        mul_a = 26'(s_q);
        mul_b = 18'(s_q);
      end
      S_SQ_C: begin
        mul_a = 26'(c_q);
        mul_b = 18'(c_q);
      end
      S_RATE_L, S_RATE_S: begin
        mul_a = rate_up ? signed'(26'h1000000 - 26'(rate_in)) : signed'(26'(rate_in));
        mul_b = signed'(18'(sce_pkg::RateK));
      end
      S_FILT_MUL: begin
        mul_a = 26'(ang_q) - 26'(last_q);
        mul_b = filt_k;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p = 44'(mul_a) * 44'(mul_b);

  // channel: floor(p / 4096) - offset, saturated
  assign ch_off = (state_q == S_MUL_S) ? sin_off_q : cos_off_q;
  assign ch_val = 21'(mul_p >>> 12) - 21'(ch_off);
  always_comb begin
    if (ch_val > 21'sd32767) begin
      ch_sat = 16'sh7fff;
    end else if (ch_val < -21'sd32768) begin
      ch_sat = 16'sh8000;
    end else begin
      ch_sat = ch_val[15:0];
    end
  end

  // rate step
  assign rate_rnd = 36'(mul_p[34:0]) + 36'h800000;
  assign rate_d   = rate_rnd[35:24];
  always_comb begin
    rate_sum = 25'(rate_in) + 25'(rate_d);
    if (rate_up) begin
      rate_new = rate_sum[24] ? 24'hffffff : rate_sum[23:0];
    end else if (24'(rate_d) > rate_in) begin
      rate_new = '0;
    end else begin
      rate_new = rate_in - 24'(rate_d);
    end
  end

  // filter accumulate and clamp
  assign filt_q   = 20'((prod_q + 36'sd32768) >>> 16);
  assign filt_sum = 21'(last_q) + 21'(filt_q);
  always_comb begin
    if (filt_sum > 21'(sce_pkg::AngleLimit)) begin
      filt_new = sce_pkg::AngleLimit;
    end else if (filt_sum < -21'(sce_pkg::AngleLimit)) begin
      filt_new = -sce_pkg::AngleLimit;
    end else begin
      filt_new = filt_sum[AB-1:0];
    end
  end

  assign cord_start = (state_q == S_RATE_S) && (status_q == sce_pkg::STATUS_VALID);

  sce_cordic u_cordic (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cord_start),
    .sin_i   (s_q),
    .cos_i   (c_q),
    .done_o  (cord_done),
    .angle_o (cord_angle)
  );

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE:     if (s_axis_tvalid) state_d = S_MUL_S;
      S_MUL_S:    state_d = S_MUL_C;
      S_MUL_C:    state_d = S_SQ_S;
      S_SQ_S:     state_d = S_SQ_C;
      S_SQ_C:     state_d = S_CHK;
      S_CHK: begin
        if (mag_q > max_mag_q) begin
          state_d = S_RATE_L;
        end else if (mag_q < min_mag_q) begin
          state_d = S_RATE_S;
        end else begin
          state_d = S_RATE_L;
        end
      end
      S_RATE_L: begin
        state_d = (status_q == sce_pkg::STATUS_VALID) ? S_RATE_S : S_OUT;
      end
      S_RATE_S: begin
        state_d = (status_q == sce_pkg::STATUS_VALID) ? S_CORD : S_OUT;
      end
      S_CORD:     if (cord_done) state_d = S_FILT_MUL;
      S_FILT_MUL: state_d = S_FILT_ADD;
      S_FILT_ADD: state_d = S_OUT;
      S_OUT:      if (m_axis_tready) state_d = S_IDLE;
      default:    state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      sin_gain_q   <= 16'sd4096;
      sin_off_q    <= '0;
      cos_gain_q   <= 16'sd4096;
      cos_off_q    <= '0;
      filt_gain_q  <= 17'h10000;
      min_mag_q    <= 32'd16777216;
      max_mag_q    <= 32'd45675725;
      status_q     <= sce_pkg::STATUS_VALID;
      large_cnt_q  <= '0;
      small_cnt_q  <= '0;
      large_rate_q <= '0;
      small_rate_q <= '0;
      last_q       <= '0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          sce_pkg::REG_SIN_GAIN:   sin_gain_q  <= cfg_data_i[15:0];
          sce_pkg::REG_SIN_OFFSET: sin_off_q   <= cfg_data_i[15:0];
          sce_pkg::REG_COS_GAIN:   cos_gain_q  <= cfg_data_i[15:0];
          sce_pkg::REG_COS_OFFSET: cos_off_q   <= cfg_data_i[15:0];
          sce_pkg::REG_FILT_GAIN:  filt_gain_q <= cfg_data_i[16:0];
          sce_pkg::REG_MIN_MAG:    min_mag_q   <= cfg_data_i;
          sce_pkg::REG_MAX_MAG:    max_mag_q   <= cfg_data_i;
          default: ;
        endcase
      end
      if (state_q == S_CHK) begin
        if (mag_q > max_mag_q) begin
          status_q    <= sce_pkg::STATUS_ABOVE;
          large_cnt_q <= large_cnt_q + 32'd1;
        end else if (mag_q < min_mag_q) begin
          status_q    <= sce_pkg::STATUS_BELOW;
          small_cnt_q <= small_cnt_q + 32'd1;
        end else begin
          status_q <= sce_pkg::STATUS_VALID;
        end
      end
      if (state_q == S_RATE_L) large_rate_q <= rate_new;
      if (state_q == S_RATE_S) small_rate_q <= rate_new;
      if (state_q == S_FILT_ADD) last_q <= filt_new;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      sin_raw_q <= s_axis_tdata[SB-1:0];
      cos_raw_q <= s_axis_tdata[2*SB-1:SB];
    end
    if (state_q == S_MUL_S) s_q <= ch_sat;
    if (state_q == S_MUL_C) c_q <= ch_sat;
    if (state_q == S_SQ_S) mag_q <= mul_p[31:0];
    if (state_q == S_SQ_C) mag_q <= mag_q + mul_p[31:0];
    if (state_q == S_CORD && cord_done) ang_q <= cord_angle;
    if (state_q == S_FILT_MUL) prod_q <= mul_p[35:0];
  end

endmodule

@@ tb/tb_top.sv @@
// Self-checking testbench for sincos_encoder_angle_top: directed table, then random
// samples over several register settings, checked by a bit-exact predictor.
// Depends on sce_pkg and the RTL of the decoder.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WatchLimit = 20000;
  localparam int DrainCycles = 40;

  typedef struct {
    logic signed [16:0] angle;
    logic [1:0]         status;
    logic [31:0]        above_cnt;
    logic [31:0]        below_cnt;
    logic [23:0]        above_rate;
    logic [23:0]        below_rate;
  } decode_t;

  typedef struct {
    logic [13:0] sine;
    logic [13:0] cosine;
    bit          typed;
    logic [1:0]  status;
  } vec_t;

  typedef struct {
    logic [15:0] sgain, soff, cgain, coff;
    logic [16:0] filt;
    logic [31:0] min_sq, max_sq;
    int          center, span;
  } setting_t;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         cfg_we_i = 1'b0;
  logic [2:0]   cfg_idx_i = '0;
  logic [31:0]  cfg_data_i = '0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [31:0]  s_axis_tdata = '0;   // sine_volts[13:0], cosine_volts[27:14]
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  // angle_deg[16:0], above_max_count[48:17], below_min_count[80:49],
  // above_max_rate[104:81], below_min_rate[128:105]
  logic [135:0] m_axis_tdata;
  logic [1:0]   m_axis_tuser;        // sample_status

  always #4 clk_i = ~clk_i;

  sincos_encoder_angle_top u_top (.*);

  // predictor state and register copy
  longint      sgain, soff, cgain, coff, filt_k;
  logic [31:0] min_sq, max_sq;
  longint      held_angle;
  logic [31:0] large_cnt, small_cnt;
  longint      large_rate, small_rate;

  decode_t expected_q[$];
  int      mismatches = 0;
  int      sent = 0;
  int      idle_cycles = 0;
  int      send_idle_pct = 37, recv_idle_pct = 52;

  function automatic longint scale(logic [13:0] v, longint g, longint o);
    longint r;
    r = ((longint'(v) * g) >>> 12) - o;
    return r < -32768 ? -32768 : (r > 32767 ? 32767 : r);
  endfunction

  function automatic longint rate_toward_one(longint r);
    longint n;
    n = r + ((((64'd16777216 - r) * sce_pkg::RateK) + 64'd8388608) >>> 24);
    return n > 16777215 ? 16777215 : n;
  endfunction

  function automatic longint rate_toward_zero(longint r);
    longint d;
    d = ((r * sce_pkg::RateK) + 64'd8388608) >>> 24;
    return d > r ? 0 : r - d;
  endfunction

  function automatic longint cordic_deg(longint s, longint c);
    longint x, y, z, t, xs, ys;
    z = 0;
    if (s == 0 && c == 0) return 0;
    x = c * 4096;
    y = s * 4096;
    if (x < 0) begin
      t = x;
      if (y >= 0) begin
        x = y; y = -t; z = 90 * 65536;
      end else begin
        x = -y; y = t; z = -90 * 65536;
      end
    end
    for (int i = 0; i < sce_pkg::CordicSteps; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y > 0) begin
        x += ys; y -= xs; z += sce_pkg::atan_q16(5'(i));
      end else begin
        x -= ys; y += xs; z -= sce_pkg::atan_q16(5'(i));
      end
    end
    z = (z + 128) >>> 8;
    return z < -46080 ? -46080 : (z > 46080 ? 46080 : z);
  endfunction

  function automatic decode_t decode_sample(logic [13:0] sv, logic [13:0] cv);
    longint s, c, k, a;
    logic [31:0] mag;
    decode_t d;
    s = scale(sv, sgain, soff);
    c = scale(cv, cgain, coff);
    mag = 32'(s * s + c * c);
    if (mag > max_sq) begin
      d.status = sce_pkg::STATUS_ABOVE;
      large_cnt++;
      large_rate = rate_toward_one(large_rate);
    end else if (mag < min_sq) begin
      d.status = sce_pkg::STATUS_BELOW;
      small_cnt++;
      small_rate = rate_toward_one(small_rate);
    end else begin
      d.status = sce_pkg::STATUS_VALID;
      k = filt_k > 65536 ? 65536 : filt_k;
      a = cordic_deg(s, c);
      large_rate = rate_toward_zero(large_rate);
      small_rate = rate_toward_zero(small_rate);
      held_angle = held_angle + (((a - held_angle) * k + 32768) >>> 16);
      if (held_angle > 46080) held_angle = 46080;
      if (held_angle < -46080) held_angle = -46080;
    end
    d.angle = 17'(held_angle);
    d.above_cnt = large_cnt;
    d.below_cnt = small_cnt;
    d.above_rate = 24'(large_rate);
    d.below_rate = 24'(small_rate);
    return d;
  endfunction

  task automatic write_reg(logic [2:0] idx, logic [31:0] val);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
  endtask

  task automatic apply_setting(setting_t st);
    write_reg(sce_pkg::REG_SIN_GAIN, {16'h0, st.sgain});
    write_reg(sce_pkg::REG_SIN_OFFSET, {16'h0, st.soff});
    write_reg(sce_pkg::REG_COS_GAIN, {16'h0, st.cgain});
    write_reg(sce_pkg::REG_COS_OFFSET, {16'h0, st.coff});
    write_reg(sce_pkg::REG_FILT_GAIN, {15'h0, st.filt});
    write_reg(sce_pkg::REG_MIN_MAG, st.min_sq);
    write_reg(sce_pkg::REG_MAX_MAG, st.max_sq);
    cfg_we_i <= 1'b0;
    sgain = longint'(signed'(st.sgain));
    soff = longint'(signed'(st.soff));
    cgain = longint'(signed'(st.cgain));
    coff = longint'(signed'(st.coff));
    filt_k = st.filt;
    min_sq = st.min_sq;
    max_sq = st.max_sq;
  endtask

  task automatic send_sample(vec_t v);
    decode_t d;
    if (sent < 150) begin
      send_idle_pct = 37; recv_idle_pct = 52;
    end else if (sent < 300) begin
      send_idle_pct = 52; recv_idle_pct = 37;
    end else begin
      send_idle_pct = 0; recv_idle_pct = 0;
    end
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {4'h0, v.cosine, v.sine};
    do @(posedge clk_i); while (!s_axis_tready);
    d = decode_sample(v.sine, v.cosine);
    if (v.typed) d.status = v.status;
    expected_q.push_back(d);
    sent++;
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  function automatic logic [13:0] pick(int center, int span);
    int v;
    if ($urandom_range(99) < 20) return 14'($urandom);
    v = center + int'($urandom_range(2 * span)) - span;
    return v < 0 ? 14'd0 : (v > 16383 ? 14'd16383 : 14'(v));
  endfunction

  // receive side: check each transfer, randomize ready
  always @(posedge clk_i) begin
    decode_t d, got;
    if (m_axis_tvalid && m_axis_tready) begin
      got.angle = m_axis_tdata[16:0];
      got.above_cnt = m_axis_tdata[48:17];
      got.below_cnt = m_axis_tdata[80:49];
      got.above_rate = m_axis_tdata[104:81];
      got.below_rate = m_axis_tdata[128:105];
      got.status = m_axis_tuser;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result transfer: %p", got);
      end else begin
        d = expected_q.pop_front();
        if (d != got) begin
          mismatches++;
          if (mismatches <= 10) $display("mismatch exp %p got %p", d, got);
        end
      end
    end
    if (rst_ni) m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // watchdog on cycles without any transfer
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || cfg_we_i)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WatchLimit) begin
      $display("Some tests failed");
      $finish;
    end
  end

  vec_t directed[] = '{
    '{14'd0, 14'd0, 1'b1, sce_pkg::STATUS_BELOW},
    '{14'd16383, 14'd16383, 1'b1, sce_pkg::STATUS_ABOVE},
    '{14'd16383, 14'd0, 1'b1, sce_pkg::STATUS_ABOVE},
    '{14'd0, 14'd16383, 1'b1, sce_pkg::STATUS_ABOVE},
    '{14'd0, 14'd4096, 1'b1, sce_pkg::STATUS_VALID},
    '{14'd4096, 14'd0, 1'b1, sce_pkg::STATUS_VALID},
    '{14'd4096, 14'd4096, 1'b1, sce_pkg::STATUS_VALID},
    '{14'd6758, 14'd0, 1'b1, sce_pkg::STATUS_VALID},    // just inside max
    '{14'd6759, 14'd0, 1'b1, sce_pkg::STATUS_ABOVE},    // just past max
    '{14'd4095, 14'd0, 1'b1, sce_pkg::STATUS_BELOW},
    '{14'd2896, 14'd2896, 1'b1, sce_pkg::STATUS_BELOW},
    '{14'd1, 14'd1, 1'b1, sce_pkg::STATUS_BELOW},
    '{14'd5000, 14'd3000, 1'b0, sce_pkg::STATUS_VALID},
    '{14'd3000, 14'd5000, 1'b0, sce_pkg::STATUS_VALID}
  };

  setting_t settings[] = '{
    '{16'd4096, 16'd0, 16'd4096, 16'd0, 17'd65536, 32'd16777216, 32'd45675725, 4000, 3000},
    // mid-rail bias: full circle around 1.65 V
    '{16'd4096, 16'd6758, 16'd4096, 16'd6758, 17'd20000, 32'd16777216, 32'd45675725,
      6758, 8000},
    // saturating extremes, everything valid, no filtering movement
    '{16'h8000, 16'h7fff, 16'h7fff, 16'h8000, 17'd0, 32'd0, 32'hffffffff, 8000, 8000},
    // only both-zero passes; filter gain above unity
    '{16'd4096, 16'd0, 16'd4096, 16'd0, 17'h1ffff, 32'd0, 32'd0, 0, 3},
    // min above max: never valid
    '{16'd4096, 16'd0, 16'd4096, 16'd0, 17'd65536, 32'hffffffff, 32'd100, 6000, 6000},
    '{16'd6000, 16'hf000, 16'd2500, 16'd3000, 17'd1234, 32'd4194304, 32'd67108864,
      5000, 6000},
    '{16'd8192, 16'd13516, 16'd8192, 16'd13516, 17'd65536, 32'd16777216, 32'd45675725,
      6758, 5000},
    '{16'hf000, 16'hf000, 16'd4096, 16'd6758, 17'd3000, 32'd8000000, 32'd60000000,
      6758, 7000}
  };

  initial begin
    vec_t v;
    sgain = 4096; soff = 0; cgain = 4096; coff = 0; filt_k = 65536;
    min_sq = 32'd16777216; max_sq = 32'd45675725;
    held_angle = 0; large_cnt = 0; small_cnt = 0; large_rate = 0; small_rate = 0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    // reset defaults first, straight from reset
    foreach (directed[i]) send_sample(directed[i]);
    wait_drained();   // sender holds off until every result is back
    foreach (settings[p]) begin
      apply_setting(settings[p]);
      for (int n = 0; n < 55; n++) begin
        v.sine = pick(settings[p].center, settings[p].span);
        v.cosine = pick(settings[p].center, settings[p].span);
        v.typed = 1'b0;
        v.status = sce_pkg::STATUS_VALID;
        send_sample(v);
      end
      wait_drained();
    end
    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

@@ sincos_encoder_angle_top.f @@
hdl/sce_pkg.sv
hdl/sce_cordic.sv
hdl/sincos_encoder_angle_top.sv
tb/tb_top.sv
